// ----- rtl/core/smallest_free_id_allocator_unit_assert.svh -----
// Assertion macros for the allocator RTL.
// Depends on nothing; included by the allocator top level.
`ifndef SMALLEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define SMALLEST_FREE_ID_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sfa_pkg.sv -----
// Shared types, constants and the lowest-set-bit encoder of the allocator.
// Depends on nothing; imported by the allocator top level and the testbench.
package sfa_pkg;

   localparam int ID_LIMIT  = 1024;
   localparam int ID_W      = 11;
   localparam int MARK_COLS = 32;
   localparam int COL_W     = $clog2(MARK_COLS);
   localparam int SLOT_W    = $clog2(ID_LIMIT);
   localparam int ROW_W     = SLOT_W - COL_W;
   localparam int MARK_ROWS = ID_LIMIT / MARK_COLS;

   typedef enum logic {
      CMD_TAKE = 1'b0,
      CMD_GIVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic            cmd;
      logic [ID_W-1:0] ident;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] smallest;
      logic            exhausted;
   } rsp_type;

   // Index of the lowest set bit; zero for an all-zero word.
   function automatic logic [COL_W-1:0] lowest_set(input logic [MARK_COLS-1:0] x);
      logic [MARK_COLS-1:0] lsb;
      logic [COL_W-1:0]     idx;
      lsb = x & (~x + MARK_COLS'(1));
      idx = '0;
      for (int i = 0; i < MARK_COLS; i++) begin
         if (lsb[i]) begin
            idx = idx | COL_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- rtl/core/sfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/smallest_free_id_allocator_unit.sv -----
// Smallest free identifier allocator: top level, sequencer and mark summary.
// Depends on sfa_pkg, sfa_ram and smallest_free_id_allocator_unit_assert.svh.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_ready | req_data  (cmd, ident)
//   rsp     | out | rsp_valid / rsp_ready | rsp_data  (smallest, exhausted)
//
// An item passes through the steps accept, row lookup and row update. The steps are set by the
// registered read of the mark memory and the one lowest-set-bit encoder, used first on the
// row summary and then on the marked row. A take with no marks, and a give-back outside
// 1 .. fresh counter - 1, skip the update. A take holds in its last step while the previous
// item waits on rsp. Reset is synchronous; it clears the summary bits, so the mark memory
// needs no clearing pass.
`include "smallest_free_id_allocator_unit_assert.svh"

module smallest_free_id_allocator_unit
   import sfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [ID_W-1:0]      ident_ff, ident_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [MARK_ROWS-1:0] summary_ff, summary_in;
   logic [ID_W-1:0]      next_fresh_ff, next_fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [ROW_W-1:0]     ram_raddr;
   logic [MARK_COLS-1:0] ram_wdata, ram_rdata;

   logic [ID_W-1:0]      ident_dec;
   logic [SLOT_W-1:0]    slot;
   logic                 give_ok;
   logic                 rsp_free;
   logic [MARK_COLS-1:0] row_word;
   logic [MARK_COLS-1:0] enc_in;
   logic [COL_W-1:0]     enc_idx;
   logic [MARK_COLS-1:0] col_bit;
   logic [MARK_COLS-1:0] row_cleared;

   sfa_ram #(
      .WIDTH (MARK_COLS),
      .DEPTH (MARK_ROWS)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ident_dec = ident_ff - ID_W'(1);
   assign slot      = ident_dec[SLOT_W-1:0];
   assign give_ok   = (ident_ff != '0) && (ident_ff < next_fresh_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // A row whose summary bit is clear is treated as empty: no marks, or unwritten since reset.
   assign row_word = summary_ff[row_ff] ? ram_rdata : '0;

   // The one shared encoder: summary in lookup, marked row in update.
   assign enc_in  = (state_ff == ST_LOOKUP) ? MARK_COLS'(summary_ff) : row_word;
   assign enc_idx = lowest_set(enc_in);

   assign col_bit     = (cmd_ff == CMD_GIVE) ?
                        (MARK_COLS'(1) << slot[COL_W-1:0]) : (MARK_COLS'(1) << enc_idx);
   assign row_cleared = row_word & ~col_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         summary_ff    <= '0;
         next_fresh_ff <= ID_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         summary_ff    <= summary_in;
         next_fresh_ff <= next_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ident_ff    <= ident_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ident_in      = ident_ff;
      row_in        = row_ff;
      summary_in    = summary_ff;
      next_fresh_in = next_fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      req_ready     = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = row_ff;
      ram_we        = 1'b0;
      ram_wdata     = row_cleared;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               ident_in = req_data.ident;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            if (cmd_ff == CMD_GIVE) begin
               if (give_ok) begin
                  ram_re    = 1'b1;
                  ram_raddr = slot[SLOT_W-1:COL_W];
                  row_in    = slot[SLOT_W-1:COL_W];
                  state_in  = ST_DATA;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (summary_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = enc_idx[ROW_W-1:0];
               row_in    = enc_idx[ROW_W-1:0];
               state_in  = ST_DATA;
            end else if (rsp_free) begin
               // No marks: hand out the fresh counter, or flag exhaustion.
               rsp_valid_in = 1'b1;
               if (next_fresh_ff <= ID_W'(ID_LIMIT)) begin
                  rsp_data_in.smallest  = next_fresh_ff;
                  rsp_data_in.exhausted = 1'b0;
                  next_fresh_in         = next_fresh_ff + ID_W'(1);
               end else begin
                  rsp_data_in.smallest  = '0;
                  rsp_data_in.exhausted = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         ST_DATA: begin
            if (cmd_ff == CMD_GIVE) begin
               // Drop a give-back of an identifier that is already marked.
               if ((row_word & col_bit) == '0) begin
                  ram_we             = 1'b1;
                  ram_wdata          = row_word | col_bit;
                  summary_in[row_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               ram_we                = 1'b1;
               ram_wdata             = row_cleared;
               summary_in[row_ff]    = |row_cleared;
               rsp_valid_in          = 1'b1;
               rsp_data_in.smallest  = ID_W'({row_ff, enc_idx}) + ID_W'(1);
               rsp_data_in.exhausted = 1'b0;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SFA_ASSERT_NOW(a_exhausted_zero, clock, reset, rsp_valid && rsp_data.exhausted,
      rsp_data.smallest == '0, "exhausted result carries a nonzero identifier")
   `SFA_ASSERT_NOW(a_fresh_range, clock, reset, 1'b1,
      (next_fresh_ff != '0) && (next_fresh_ff <= ID_W'(ID_LIMIT + 1)),
      "fresh counter out of range")
   `SFA_ASSERT_NOW(a_write_in_update, clock, reset, ram_we, state_ff == ST_DATA,
      "mark memory written outside the update step")
   `SFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "ready while an item is in progress")
   `SFA_ASSERT_NEXT(a_issued_below_fresh, clock, reset,
      rsp_valid_in && !rsp_data_in.exhausted && (state_ff != ST_IDLE)
         && !(rsp_valid_ff && !rsp_ready),
      (rsp_data.smallest != '0) && (rsp_data.smallest < next_fresh_ff),
      "issued identifier not below the fresh counter")

endmodule

// ----- tb/sv/smallest_free_id_allocator_unit_tb.sv -----
// Self-checking testbench for the smallest free identifier allocator.
// Depends on sfa_pkg and smallest_free_id_allocator_unit; checks every take result in
// order against a predictor of the identifier pool, or against a typed-in result.
`timescale 1ns / 1ps

module smallest_free_id_allocator_unit_tb;
   import sfa_pkg::*;

   localparam int CLK_HALF   = 6;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_WAIT = 20;
   localparam int LONG_HOLD  = 400;
   localparam int SCRIPT_LEN = 24;

   typedef struct {
      cmd_type         cmd;
      logic [ID_W-1:0] ident;
      bit              typed;
      rsp_type         want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // pool model
   int unsigned fresh_ctr;
   bit          mark_bits [0:2**ID_W-1];

   rsp_type     grant_q [$];
   int unsigned held_ids [$];
   int unsigned gone_ids [$];

   int  mismatch_cnt = 0;
   int  rsp_count = 0;
   int  useful_items = 0;
   int  exhaust_hits = 0;
   int  idle_cycles = 0;
   int  take_pct = 50;
   bit  burst_mode = 1'b0;

   // directed sequence; only obvious results are typed in
   script_row_type alloc_script [SCRIPT_LEN] = '{
      '{CMD_TAKE, 11'd0,    1'b1, '{11'd1, 1'b0}},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_GIVE, 11'd0,    1'b0, '0},
      '{CMD_GIVE, 11'd2047, 1'b0, '0},
      '{CMD_GIVE, 11'd1024, 1'b0, '0},
      '{CMD_GIVE, 11'd4,    1'b0, '0},
      '{CMD_GIVE, 11'd2,    1'b0, '0},
      '{CMD_GIVE, 11'd2,    1'b0, '0},
      '{CMD_GIVE, 11'd1,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_GIVE, 11'd3,    1'b0, '0},
      '{CMD_GIVE, 11'd1,    1'b0, '0},
      '{CMD_GIVE, 11'd3,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_TAKE, 11'd0,    1'b0, '0},
      '{CMD_GIVE, 11'd1365, 1'b0, '0},
      '{CMD_GIVE, 11'd682,  1'b0, '0},
      '{CMD_TAKE, 11'd2047, 1'b0, '0},
      '{CMD_GIVE, 11'd5,    1'b0, '0},
      '{CMD_TAKE, 11'd1024, 1'b0, '0}
   };

   smallest_free_id_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   // Advance the pool by one item; returns 1 when the item yields a result.
   function automatic bit pool_step(input req_type item, output rsp_type res);
      int unsigned low;
      res = '0;
      low = 0;
      if (item.cmd == CMD_GIVE) begin
         if (item.ident != 0 && item.ident < fresh_ctr && !mark_bits[item.ident]) begin
            mark_bits[item.ident] = 1'b1;
         end
         return 1'b0;
      end
      for (int i = 1; i < fresh_ctr && i <= ID_LIMIT; i++) begin
         if (low == 0 && mark_bits[i]) begin
            low = i;
         end
      end
      if (low != 0) begin
         mark_bits[low] = 1'b0;
         res.smallest = ID_W'(low);
      end else if (fresh_ctr <= ID_LIMIT) begin
         res.smallest = ID_W'(fresh_ctr);
         fresh_ctr++;
      end else begin
         res.exhausted = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic void drop_id(ref int unsigned ids [$], input int unsigned v);
      for (int i = 0; i < ids.size(); i++) begin
         if (ids[i] == v) begin
            ids.delete(i);
            return;
         end
      end
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic issue_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type predicted;
      bit      has_rsp;
      bit      was_marked;
      int      gap;
      was_marked = mark_bits[item.ident];
      has_rsp = pool_step(item, predicted);
      if (has_rsp) begin
         grant_q.push_back(typed ? want : predicted);
         useful_items++;
         if (predicted.exhausted) begin
            exhaust_hits++;
         end else begin
            held_ids.push_back(predicted.smallest);
            drop_id(gone_ids, predicted.smallest);
         end
      end else if (!was_marked && mark_bits[item.ident]) begin
         useful_items++;
         drop_id(held_ids, item.ident);
         gone_ids.push_back(item.ident);
      end
      gap = burst_mode ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly takes and returns of held identifiers; the rest is noise.
   task automatic random_phase(input int target);
      req_type item;
      int      goal;
      int      p;
      goal = useful_items + target;
      while (useful_items < goal) begin
         if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
         if ($urandom_range(0, 49) == 0) take_pct = $urandom_range(0, 1) ? 65 : 30;
         p = $urandom_range(0, 99);
         item.cmd   = CMD_GIVE;
         item.ident = ID_W'($urandom_range(0, 2**ID_W - 1));
         if (p < take_pct || (p < 85 && held_ids.size() == 0)) begin
            item.cmd = CMD_TAKE;
         end else if (p < 85) begin
            item.ident = ID_W'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
         end else if (p < 90 && gone_ids.size() != 0) begin
            item.ident = ID_W'(gone_ids[$urandom_range(0, gone_ids.size() - 1)]);
         end else if (p < 95) begin
            item.ident = $urandom_range(0, 3) == 0 ? '0 :
                         ID_W'($urandom_range(fresh_ctr, 2**ID_W - 1));
         end
         issue_item(item, 1'b0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (grant_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("result %0d: none expected, got smallest=%0d exhausted=%0b",
                        rsp_count, rsp_data.smallest, rsp_data.exhausted);
         end else begin
            exp_rsp = grant_q.pop_front();
            if (rsp_data.smallest !== exp_rsp.smallest ||
                rsp_data.exhausted !== exp_rsp.exhausted) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("result %0d: expected smallest=%0d exhausted=%0b, got %0d %0b",
                           rsp_count, exp_rsp.smallest, exp_rsp.exhausted,
                           rsp_data.smallest, rsp_data.exhausted);
            end
         end
      end
   end

   // receiver: random stalls, calm stretches, and one long hold to back up the block
   always @(negedge clock) begin
      static int  stall_left = 0;
      static bit  rx_calm = 1'b0;
      static bit  long_hold_done = 1'b0;
      if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!long_hold_done && rsp_count >= 150) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rx_calm && $urandom_range(0, 99) < 20)
            stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(5, 30) :
                         $urandom_range(1, 3);
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_type item;
      fresh_ctr = 1;
      foreach (mark_bits[i]) mark_bits[i] = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         item.cmd   = alloc_script[i].cmd;
         item.ident = alloc_script[i].ident;
         issue_item(item, alloc_script[i].typed, alloc_script[i].want);
      end

      random_phase(700);

      // drain the pool until takes come back exhausted
      item.cmd = CMD_TAKE;
      while (exhaust_hits < 3) begin
         item.ident = ID_W'($urandom_range(0, 2**ID_W - 1));
         issue_item(item, 1'b0, '0);
      end
      issue_item('{CMD_GIVE, 11'd1024}, 1'b0, '0);
      issue_item('{CMD_GIVE, 11'd1}, 1'b0, '0);
      issue_item('{CMD_TAKE, 11'd0}, 1'b1, '{11'd1, 1'b0});
      issue_item('{CMD_TAKE, 11'd0}, 1'b1, '{11'd1024, 1'b0});
      issue_item('{CMD_TAKE, 11'd0}, 1'b1, '{11'd0, 1'b1});

      random_phase(150);

      @(negedge clock);
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- smallest_free_id_allocator_unit.f -----
+incdir+rtl/core
rtl/core/sfa_pkg.sv
rtl/core/sfa_ram.sv
rtl/core/smallest_free_id_allocator_unit.sv
tb/sv/smallest_free_id_allocator_unit_tb.sv
